FILE: design/sac_pkg.sv
// Shared types, codes and defaults for the set-associative cache tag model.
package sac_pkg;

  // Address and counter widths fixed by the data path
  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;
  localparam int OB_W   = 6;
  localparam int SB_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Default geometry
  localparam int DEF_SETS = 256;
  localparam int DEF_WAYS = 4;

  // Configuration reset values
  localparam logic [OB_W-1:0] RST_OFFSET_BITS = 6'd6;
  localparam logic [SB_W-1:0] RST_SET_BITS    = 4'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_SET_BITS    = 2'd1,
    CFG_USE_LFU     = 2'd2
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_FILL  = 2'd1,
    ST_EVICT = 2'd2
  } status_t;

  // One stored way
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] stamp;
    logic [CNT_W-1:0]  uses;
  } way_t;

  // Saturating increment of a 32-bit count
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: design/set_assoc_cache_lru_lfu.sv
// Top level: set-associative tag cache with LRU or LFU replacement.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in_     | input     | in_valid / in_stall   | in_access_address
//   out_    | output    | out_valid / out_stall | status, victim, insert, three totals
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// A hit or a fill into an empty way is registered with its set row read and then
// resolved in the lookup stage, so such items stream at one per cycle while the
// output is not stalled; the result register loads when the lookup finishes.
// A miss into a full set passes, when WAYS > 1, through victim scan states that run
// the serial way-by-way victim compare, then an eviction state that writes the line.
// After reset a clearing pass writes every set row to zero, with the input
// stalled. A stalled output holds its result; the block waits in place.
module set_assoc_cache_lru_lfu #(
  parameter int SETS = sac_pkg::DEF_SETS,
  parameter int WAYS = sac_pkg::DEF_WAYS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sac_pkg::ADDR_W-1:0]        in_access_address,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output sac_pkg::status_t                  out_status,
  output logic [sac_pkg::ADDR_W-1:0]        out_victim_addr,
  output logic [sac_pkg::ADDR_W-1:0]        out_fill_addr,
  output logic [sac_pkg::CNT_W-1:0]         out_hit_total,
  output logic [sac_pkg::CNT_W-1:0]         out_miss_total,
  output logic [sac_pkg::CNT_W-1:0]         out_eviction_total,
  // configuration port
  input  logic                              cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sac_pkg::*;

  localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MAX_SB = $clog2(SETS + 1) - 1;

  typedef struct packed {
    way_t [WAYS-1:0]   ways;
    logic [ADDR_W-1:0] set_clock;
  } row_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EVICT = 5'b10000
  } state_t;

  // Configuration registers
  logic [OB_W-1:0] offset_bits_r;
  logic [SB_W-1:0] set_bits_r;
  logic            use_lfu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= RST_OFFSET_BITS;
      set_bits_r    <= RST_SET_BITS;
      use_lfu_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata[OB_W-1:0];
        CFG_SET_BITS:    set_bits_r    <= cfg_wdata[SB_W-1:0];
        CFG_USE_LFU:     use_lfu_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Address split under the current configuration
  logic [SB_W-1:0]   sb_eff;
  logic [OB_W:0]     tag_shift;
  logic [ADDR_W-1:0] idx_mask;
  logic [ADDR_W-1:0] in_set_full;
  logic [SET_AW-1:0] in_set;
  logic [ADDR_W-1:0] in_tag;
  logic [ADDR_W-1:0] in_blk;

  always_comb begin
    sb_eff      = ({1'b0, set_bits_r} > 5'(MAX_SB)) ? SB_W'(MAX_SB) : set_bits_r;
    tag_shift   = {1'b0, offset_bits_r} + (OB_W+1)'(sb_eff);
    idx_mask    = (ADDR_W'(1) << sb_eff) - ADDR_W'(1);
    in_set_full = (in_access_address >> offset_bits_r) & idx_mask;
    in_set      = in_set_full[SET_AW-1:0];
    in_tag      = tag_shift[OB_W] ? '0 : (in_access_address >> tag_shift[OB_W-1:0]);
    in_blk      = in_access_address & ~((ADDR_W'(1) << offset_bits_r) - ADDR_W'(1));
  end

  // Control and item registers
  state_t            state_r, state_nxt;
  logic [SET_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              fwd_r, fwd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic [CNT_W-1:0]  misses_r, misses_nxt;
  logic [CNT_W-1:0]  evicts_r, evicts_nxt;
  logic [WAY_W-1:0]  k_r, k_nxt;
  logic [WAY_W-1:0]  best_r, best_nxt;

  logic [SET_AW-1:0] set_r;
  logic [ADDR_W-1:0] tag_r;
  logic [ADDR_W-1:0] blk_r;
  row_t              rd_row_r;
  row_t              fwd_row_r;
  row_t              scan_row_r, scan_row_nxt;
  status_t           status_r, status_nxt;
  logic [ADDR_W-1:0] victim_r, victim_nxt;
  logic [ADDR_W-1:0] insert_r, insert_nxt;

  // Memory port signals
  logic              mem_we;
  logic [SET_AW-1:0] mem_waddr;
  row_t              mem_wdata;
  logic              in_accept;
  logic              fin;

  // Lookup stage signals
  row_t              cur_row;
  row_t              look_row;
  logic [ADDR_W-1:0] clk_new;
  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   free_vec;
  logic [WAY_W-1:0]  hit_idx;
  logic [WAY_W-1:0]  free_idx;
  logic              hit_any;
  logic              free_any;
  logic              out_free;

  // Scan and eviction signals
  way_t              way_a;
  way_t              way_b;
  logic              better;
  row_t              ev_row;
  logic [ADDR_W-1:0] victim_tag_part;

  // Hit and free way detection on the (forwarded) row
  always_comb begin
    cur_row  = fwd_r ? fwd_row_r : rd_row_r;
    clk_new  = cur_row.set_clock + ADDR_W'(1);
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = cur_row.ways[w].valid && (cur_row.ways[w].tag == tag_r);
      free_vec[w] = !cur_row.ways[w].valid;
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_idx = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_idx = WAY_W'(w);
      end
    end
    hit_any  = |hit_vec;
    free_any = |free_vec;

    look_row           = cur_row;
    look_row.set_clock = clk_new;
    if (hit_any) begin
      look_row.ways[hit_idx].stamp = clk_new;
      look_row.ways[hit_idx].uses  = sat_inc(cur_row.ways[hit_idx].uses);
    end else if (free_any) begin
      look_row.ways[free_idx] = '{valid: 1'b1, tag: tag_r, stamp: clk_new,
                                  uses: CNT_W'(1)};
    end
  end

  // One way compare per scan cycle
  always_comb begin
    way_a = scan_row_r.ways[k_r];
    way_b = scan_row_r.ways[best_r];
    if (use_lfu_r) begin
      better = (way_a.uses < way_b.uses) ||
               ((way_a.uses == way_b.uses) && (way_a.stamp < way_b.stamp));
    end else begin
      better = way_a.stamp < way_b.stamp;
    end
  end

  // Victim line and address rebuild
  always_comb begin
    ev_row               = scan_row_r;
    ev_row.ways[best_r]  = '{valid: 1'b1, tag: tag_r, stamp: scan_row_r.set_clock,
                             uses: CNT_W'(1)};
    victim_tag_part      = tag_shift[OB_W] ? '0 :
                           (scan_row_r.ways[best_r].tag << tag_shift[OB_W-1:0]);
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign fin       = out_free &&
                     (((state_r == S_LOOK) && (hit_any || free_any)) ||
                      (state_r == S_EVICT));
  assign in_stall  = !((state_r == S_IDLE) || fin);
  assign in_accept = in_valid && !in_stall;

  // Sequencer and result build
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    fwd_nxt       = fwd_r;
    out_valid_nxt = out_valid_r && out_stall;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    evicts_nxt    = evicts_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    scan_row_nxt  = scan_row_r;
    status_nxt    = status_r;
    victim_nxt    = victim_r;
    insert_nxt    = insert_r;
    mem_we        = 1'b0;
    mem_waddr     = set_r;
    mem_wdata     = look_row;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + SET_AW'(1);
        if (clr_cnt_r == SET_AW'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!hit_any && !free_any) begin
          scan_row_nxt = look_row;
          best_nxt     = '0;
          k_nxt        = WAY_W'(1);
          state_nxt    = (WAYS > 1) ? S_SCAN : S_EVICT;
        end else if (fin) begin
          mem_we        = 1'b1;
          mem_wdata     = look_row;
          out_valid_nxt = 1'b1;
          victim_nxt    = '0;
          if (hit_any) begin
            hits_nxt   = sat_inc(hits_r);
            status_nxt = ST_HIT;
            insert_nxt = '0;
          end else begin
            misses_nxt = sat_inc(misses_r);
            status_nxt = ST_FILL;
            insert_nxt = blk_r;
          end
          state_nxt = in_accept ? S_LOOK : S_IDLE;
        end
      end
      S_SCAN: begin
        if (better) begin
          best_nxt = k_r;
        end
        k_nxt = k_r + WAY_W'(1);
        if (k_r == WAY_W'(WAYS - 1)) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        if (fin) begin
          mem_we        = 1'b1;
          mem_wdata     = ev_row;
          out_valid_nxt = 1'b1;
          misses_nxt    = sat_inc(misses_r);
          evicts_nxt    = sat_inc(evicts_r);
          status_nxt    = ST_EVICT;
          insert_nxt    = blk_r;
          victim_nxt    = victim_tag_part |
                          (ADDR_W'(set_r) << offset_bits_r);
          state_nxt     = in_accept ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Forward the row written in this cycle when the next item reads the same set
    if (in_accept) begin
      fwd_nxt = mem_we && (mem_waddr == in_set);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      k_r         <= '0;
      best_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      evicts_r    <= evicts_nxt;
      k_r         <= k_nxt;
      best_r      <= best_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      set_r     <= in_set;
      tag_r     <= in_tag;
      blk_r     <= in_blk;
      fwd_row_r <= mem_wdata;
    end
    scan_row_r <= scan_row_nxt;
    status_r   <= status_nxt;
    victim_r   <= victim_nxt;
    insert_r   <= insert_nxt;
  end

  // Set row memory: one write port, one registered read port
  row_t mem [SETS];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_row_r <= mem[in_set];
    end
  end

  // Drive the result beat
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_victim_addr    = victim_r;
  assign out_fill_addr      = insert_r;
  assign out_hit_total      = hits_r;
  assign out_miss_total     = misses_r;
  assign out_eviction_total = evicts_r;

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("input accepted during clearing pass");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r)
    else $error("finished item did not load the output register");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_r) |-> $past(mem_we))
    else $error("forwarding set without a write in the accept cycle");

  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_EVICT)) |-> (victim_r == '0))
    else $error("victim address set on a result without eviction");

  a_hit_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_HIT)) |-> (insert_r == '0))
    else $error("insert address set on a hit");

endmodule
